FILE: rtl/pfpe_pkg.sv
`timescale 1ns / 1ps

package pfpe_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_IMAGE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
    logic [7:0] image_byte;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [9:0] read_index_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PX_RD,
    ST_PX_WR,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

endpackage

FILE: rtl/pfpe_ram.sv
`timescale 1ns / 1ps

module pfpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/page_framebuffer_pixel_engine_core.sv
`timescale 1ns / 1ps

// Page-major monochrome framebuffer, PANEL_WIDTH x PANEL_HEIGHT, one byte per
// column per 8-row page (bit = y mod 8), held in one synchronous RAM. After
// reset the RAM is swept to zero, one byte a cycle, and in_ready stays low
// meanwhile. Items are taken one at a time. A pixel write is a read-modify-
// write on the single RAM, a read then a write back; an image byte write does
// this for eight pixels in turn. A buffer read passes ST_RD_ADDR and
// ST_RD_DATA to the result register. Off-panel pixels are dropped; a read
// beyond the store returns zero. The result register lets the next item start
// while a read result waits on out_ready.
module page_framebuffer_pixel_engine_core #(
  parameter int PANEL_WIDTH  = pfpe_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pfpe_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfpe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pfpe_pkg::out_item_t out_item
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_DEPTH);

  pfpe_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [7:0]          px_r, px_nxt;
  logic [7:0]          py_r, py_nxt;
  logic [7:0]          img_r, img_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [9:0]          ridx_r, ridx_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  pfpe_pkg::out_item_t out_item_r, out_item_nxt;

  logic                ram_we;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;
  logic [7:0]          col_sel;
  logic [7:0]          row_sel;
  logic [AW-1:0]       pix_addr;
  logic                cur_in_panel;
  logic                in_fire;
  logic [7:0]          bit_mask;

  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign bit_mask  = 8'b1 << py_r[2:0];

  assign pix_addr = AW'(32'(row_sel[7:3]) * 32'(PANEL_WIDTH) + 32'(col_sel));
  assign cur_in_panel = ({1'b0, px_r} < 9'(PANEL_WIDTH)) &&
                        ({1'b0, py_r} < 9'(PANEL_HEIGHT));

  pfpe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfpe_pkg::ST_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    img_r      <= img_nxt;
    cnt_r      <= cnt_nxt;
    ridx_r     <= ridx_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    img_nxt       = img_r;
    cnt_nxt       = cnt_r;
    ridx_nxt      = ridx_r;
    rd_ok_nxt     = rd_ok_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    col_sel       = px_r + 8'd1;
    row_sel       = py_r;

    case (state_r)
      pfpe_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(STORE_DEPTH - 1)) begin
          addr_nxt  = '0;
          state_nxt = pfpe_pkg::ST_IDLE;
        end
      end

      pfpe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        row_sel  = in_item.y;
        col_sel  = in_item.x;
        if (in_item.req_type == pfpe_pkg::REQ_IMAGE) begin
          col_sel = {in_item.x[7:3], 3'b000};
        end
        if (in_fire) begin
          case (in_item.req_type)
            pfpe_pkg::REQ_PIXEL: begin
              px_nxt    = in_item.x;
              py_nxt    = in_item.y;
              img_nxt   = {in_item.color, 7'b0};
              cnt_nxt   = 3'd0;
              addr_nxt  = pix_addr;
              state_nxt = pfpe_pkg::ST_PX_RD;
            end
            pfpe_pkg::REQ_IMAGE: begin
              px_nxt    = {in_item.x[7:3], 3'b000};
              py_nxt    = in_item.y;
              img_nxt   = in_item.image_byte;
              cnt_nxt   = 3'd7;
              addr_nxt  = pix_addr;
              state_nxt = pfpe_pkg::ST_PX_RD;
            end
            pfpe_pkg::REQ_READ: begin
              ridx_nxt  = in_item.read_index;
              rd_ok_nxt = (32'(in_item.read_index) < 32'(STORE_DEPTH));
              addr_nxt  = AW'(32'(in_item.read_index));
              state_nxt = pfpe_pkg::ST_RD_ADDR;
            end
            default: begin
              state_nxt = pfpe_pkg::ST_IDLE;
            end
          endcase
        end
      end

      pfpe_pkg::ST_PX_RD: begin
        state_nxt = pfpe_pkg::ST_PX_WR;
      end

      pfpe_pkg::ST_PX_WR: begin
        ram_we    = cur_in_panel;
        ram_wdata = img_r[7] ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        if (cnt_r == 3'd0) begin
          state_nxt = pfpe_pkg::ST_IDLE;
        end else begin
          px_nxt    = px_r + 8'd1;
          img_nxt   = {img_r[6:0], 1'b0};
          cnt_nxt   = cnt_r - 3'd1;
          addr_nxt  = pix_addr;
          state_nxt = pfpe_pkg::ST_PX_RD;
        end
      end

      pfpe_pkg::ST_RD_ADDR: begin
        state_nxt = pfpe_pkg::ST_RD_DATA;
      end

      pfpe_pkg::ST_RD_DATA: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.read_data      = rd_ok_r ? ram_rdata : 8'd0;
          out_item_nxt.read_index_out = ridx_r;
          state_nxt                   = pfpe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pfpe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
